### hdl/cwtc_pkg.sv
package cwtc_pkg;

    // Geometry of the cache and of the backing memory. All counts are powers of two,
    // so address fields are taken apart with part-selects.
    localparam int LINES          = 8;
    localparam int WORDS_PER_LINE = 4;
    localparam int SETS           = 4;
    localparam int MEM_LINES      = 512;

    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 11;
    localparam int WAY_W      = $clog2(LINES);
    localparam int SET_W      = $clog2(SETS);
    localparam int OFF_W      = $clog2(WORDS_PER_LINE);
    localparam int LINE_W     = ADDR_W - OFF_W;
    localparam int TAG_W      = LINE_W;
    localparam int LW_DEPTH   = LINES * WORDS_PER_LINE;
    localparam int LW_ADDR_W  = $clog2(LW_DEPTH);
    localparam int MEM_DEPTH  = MEM_LINES * WORDS_PER_LINE;
    localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);
    localparam int SCAN_W     = WAY_W + 1;
    localparam int FILL_W     = OFF_W + 1;

    // Modeled cost of one cache access and of one memory access.
    localparam logic [DATA_W-1:0] CACHE_COST = 32'd2;
    localparam logic [DATA_W-1:0] MEM_COST   = 32'd100;

    typedef enum logic [1:0] {
        ORG_DIRECT  = 2'd0,
        ORG_TWO_WAY = 2'd1,
        ORG_FULL    = 2'd2,
        ORG_INVALID = 2'd3
    } org_t;

    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_CLEAR = 2'd2;

    typedef struct packed {
        logic        [1:0]        mode;
        logic        [ADDR_W-1:0] address;
        logic signed [DATA_W-1:0] write_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] read_data;
        logic                     hit;
        logic                     org_error;
        logic        [DATA_W-1:0] total_time;
        logic        [DATA_W-1:0] miss_total;
    } rsp_t;

endpackage

### hdl/cwtc_ram.sv
module cwtc_ram #(
    parameter int DATA_W = 32,
    parameter int DEPTH  = 32,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // One write port and one read port; the read data is registered.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/configurable_write_through_cache_unit.sv
// Channel   Direction  Handshake                  Payload
// req       in         req_valid / req_ready      cwtc_pkg::req_t (mode, address, write_value)
// rsp       out        rsp_valid / rsp_ready      cwtc_pkg::rsp_t (read_data, hit, org_error,
//                                                 total_time, miss_total)
// apb       in/out     psel, penable, pwrite      organization at byte address 0
//
// One item is handled at a time by a small sequencer around a single tag compare and
// age subtractor. The ways of the addressed set are examined one per cycle: all N of
// them on a miss (N = 1 direct, 2 two-way, 8 fully), and W of them on a hit, where the
// scan stops at the matching way. A read hit then reads the word from the registered
// line store, a write hit writes line and memory, and a miss passes through a miss
// state, a four-word refill through the registered memory port and the result state;
// a clear, an ignored mode or the invalid organization goes straight to the result.
// After reset a clearing pass zeroes the 2048-word backing memory, one word per cycle,
// with req_ready low until it ends; configuration writes are taken throughout.
// A result waits in the rsp register while rsp_ready is low; the next item is taken
// as soon as the sequencer is back in idle.
module configurable_write_through_cache_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cwtc_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output cwtc_pkg::rsp_t rsp,
    input  logic           psel,
    input  logic           penable,
    input  logic           pwrite,
    input  logic [2:0]     paddr,
    input  logic [31:0]    pwdata,
    output logic [31:0]    prdata,
    output logic           pready
);

    import cwtc_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_HIT_RD,
        S_LOAD,
        S_HIT_WR,
        S_MISS,
        S_FILL,
        S_DONE
    } state_t;

    // Control and result state.
    state_t                 state_reg,       state_next;
    logic [MEM_ADDR_W-1:0]  clr_cnt_reg,     clr_cnt_next;
    org_t                   org_reg,         org_next;
    logic [DATA_W-1:0]      stamp_reg,       stamp_next;
    logic [DATA_W-1:0]      time_reg,        time_next;
    logic [DATA_W-1:0]      miss_reg,        miss_next;
    logic [1:0]             mode_reg,        mode_next;
    logic [ADDR_W-1:0]      addr_reg,        addr_next;
    logic [DATA_W-1:0]      wval_reg,        wval_next;
    logic [TAG_W-1:0]       tag_req_reg,     tag_req_next;
    logic [SCAN_W-1:0]      step_reg,        step_next;
    logic [SCAN_W-1:0]      scan_idx_reg,    scan_idx_next;
    logic [WAY_W-1:0]       victim_reg,      victim_next;
    logic [DATA_W-1:0]      least_reg,       least_next;
    logic                   victim_done_reg, victim_done_next;
    logic [WAY_W-1:0]       way_reg,         way_next;
    logic [FILL_W-1:0]      fill_cnt_reg,    fill_cnt_next;
    logic [DATA_W-1:0]      rdata_reg,       rdata_next;
    logic                   hit_reg,         hit_next;
    logic [LINES-1:0]       valid_reg,       valid_next;
    logic                   rsp_valid_reg,   rsp_valid_next;
    rsp_t                   rsp_reg,         rsp_next;

    // Per-line tag and last-use stamp; written before they are ever read.
    logic [TAG_W-1:0]       line_tag_reg      [LINES];
    logic [DATA_W-1:0]      line_last_use_reg [LINES];

    logic                   tag_we;
    logic                   lu_we;
    logic [WAY_W-1:0]       lu_way;

    // Shared datapath: one adder for modeled time, one compare and one subtract for lookup.
    logic [DATA_W-1:0]      time_inc;
    logic                   time_clr;
    logic [WAY_W-1:0]       cur_way;
    logic                   way_hit;
    logic [DATA_W-1:0]      age;
    logic [SCAN_W-1:0]      scan_sum;
    logic                   scan_last;
    logic [LINE_W-1:0]      req_line;
    logic [FILL_W-1:0]      fill_prev;
    logic                   rsp_load;

    // Memory ports.
    logic                   mem_we;
    logic [MEM_ADDR_W-1:0]  mem_wr_addr;
    logic [DATA_W-1:0]      mem_wr_data;
    logic [MEM_ADDR_W-1:0]  mem_rd_addr;
    logic [DATA_W-1:0]      mem_rd_data;
    logic                   lw_we;
    logic [LW_ADDR_W-1:0]   lw_wr_addr;
    logic [DATA_W-1:0]      lw_wr_data;
    logic [LW_ADDR_W-1:0]   lw_rd_addr;
    logic [DATA_W-1:0]      lw_rd_data;

    cwtc_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (MEM_DEPTH)
    ) u_backing_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    cwtc_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (LW_DEPTH)
    ) u_line_words (
        .clk     (clk),
        .wr_en   (lw_we),
        .wr_addr (lw_wr_addr),
        .wr_data (lw_wr_data),
        .rd_addr (lw_rd_addr),
        .rd_data (lw_rd_data)
    );

    // Configuration port. There is a single register, so only paddr[2] decodes.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? 32'(org_reg) : 32'd0;

    // Handshakes.
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Lookup datapath on the way currently being examined.
    assign cur_way   = scan_idx_reg[WAY_W-1:0];
    assign way_hit   = valid_reg[cur_way] && (line_tag_reg[cur_way] == tag_req_reg);
    assign age       = stamp_reg - line_last_use_reg[cur_way];
    assign scan_sum  = scan_idx_reg + step_reg;
    assign scan_last = (scan_sum >= SCAN_W'(LINES));
    assign req_line  = req.address[ADDR_W-1:OFF_W];
    assign fill_prev = fill_cnt_reg - FILL_W'(1);

    // The backing memory is word addressed by the item's address; the refill reads
    // the words of the addressed line in order.
    assign mem_rd_addr = {addr_reg[ADDR_W-1:OFF_W], fill_cnt_reg[OFF_W-1:0]};
    assign lw_rd_addr  = {way_reg, addr_reg[OFF_W-1:0]};

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        org_next         = org_reg;
        stamp_next       = stamp_reg;
        miss_next        = miss_reg;
        mode_next        = mode_reg;
        addr_next        = addr_reg;
        wval_next        = wval_reg;
        tag_req_next     = tag_req_reg;
        step_next        = step_reg;
        scan_idx_next    = scan_idx_reg;
        victim_next      = victim_reg;
        least_next       = least_reg;
        victim_done_next = victim_done_reg;
        way_next         = way_reg;
        fill_cnt_next    = fill_cnt_reg;
        rdata_next       = rdata_reg;
        hit_next         = hit_reg;
        valid_next       = valid_reg;
        rsp_next         = rsp_reg;
        rsp_load         = 1'b0;
        time_inc         = '0;
        time_clr         = 1'b0;
        tag_we           = 1'b0;
        lu_we            = 1'b0;
        lu_way           = way_reg;
        mem_we           = 1'b0;
        mem_wr_addr      = addr_reg;
        mem_wr_data      = wval_reg;
        lw_we            = 1'b0;
        lw_wr_addr       = {way_reg, addr_reg[OFF_W-1:0]};
        lw_wr_data       = wval_reg;

        if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
        begin
            org_next = org_t'(pwdata[1:0]);
        end

        case (state_reg)
            S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                mem_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + MEM_ADDR_W'(1);
                if (clr_cnt_reg == MEM_ADDR_W'(MEM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (req_valid)
                begin
                    mode_next  = req.mode;
                    addr_next  = req.address;
                    wval_next  = req.write_value;
                    rdata_next = '0;
                    hit_next   = 1'b0;
                    case (req.mode)
                        MODE_CLEAR:
                        begin
                            time_clr   = 1'b1;
                            miss_next  = '0;
                            state_next = S_DONE;
                        end
                        MODE_READ, MODE_WRITE:
                        begin
                            stamp_next = stamp_reg + DATA_W'(1);
                            if (org_reg == ORG_INVALID)
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                time_inc         = CACHE_COST;
                                least_next       = '0;
                                victim_done_next = 1'b0;
                                state_next       = S_SCAN;
                                case (org_reg)
                                    ORG_DIRECT:
                                    begin
                                        scan_idx_next = SCAN_W'(req_line[WAY_W-1:0]);
                                        step_next     = SCAN_W'(LINES);
                                        tag_req_next  = TAG_W'(req_line >> WAY_W);
                                    end
                                    ORG_TWO_WAY:
                                    begin
                                        scan_idx_next = SCAN_W'(req_line[SET_W-1:0]);
                                        step_next     = SCAN_W'(SETS);
                                        tag_req_next  = req_line;
                                    end
                                    default:
                                    begin
                                        scan_idx_next = '0;
                                        step_next     = SCAN_W'(1);
                                        tag_req_next  = req_line;
                                    end
                                endcase
                                victim_next = scan_idx_next[WAY_W-1:0];
                            end
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (way_hit)
                begin
                    hit_next   = 1'b1;
                    way_next   = cur_way;
                    lu_we      = 1'b1;
                    lu_way     = cur_way;
                    state_next = (mode_reg == MODE_WRITE) ? S_HIT_WR : S_HIT_RD;
                end
                else
                begin
                    // Victim choice: first invalid way, else the oldest by stamp age,
                    // the earliest way winning ties.
                    if (!victim_done_reg)
                    begin
                        if (!valid_reg[cur_way])
                        begin
                            victim_next      = cur_way;
                            victim_done_next = 1'b1;
                        end
                        else if (age > least_reg)
                        begin
                            victim_next = cur_way;
                            least_next  = age;
                        end
                    end
                    if (scan_last)
                    begin
                        way_next   = victim_next;
                        state_next = S_MISS;
                    end
                    else
                    begin
                        scan_idx_next = scan_sum;
                    end
                end
            end

            S_HIT_RD:
            begin
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                rdata_next = lw_rd_data;
                state_next = S_DONE;
            end

            S_HIT_WR:
            begin
                lw_we      = 1'b1;
                mem_we     = 1'b1;
                time_inc   = MEM_COST;
                state_next = S_DONE;
            end

            S_MISS:
            begin
                miss_next     = miss_reg + DATA_W'(1);
                fill_cnt_next = '0;
                state_next    = S_FILL;
                // A write miss updates memory before the line is refilled from it.
                if (mode_reg == MODE_WRITE)
                begin
                    mem_we   = 1'b1;
                    time_inc = MEM_COST;
                end
            end

            S_FILL:
            begin
                // Memory reads run one word ahead of the line writes.
                if (fill_cnt_reg != '0)
                begin
                    lw_we      = 1'b1;
                    lw_wr_addr = {way_reg, fill_prev[OFF_W-1:0]};
                    lw_wr_data = mem_rd_data;
                    if ((mode_reg == MODE_READ) &&
                        (fill_prev[OFF_W-1:0] == addr_reg[OFF_W-1:0]))
                    begin
                        rdata_next = mem_rd_data;
                    end
                end
                if (fill_cnt_reg == FILL_W'(WORDS_PER_LINE))
                begin
                    time_inc            = MEM_COST;
                    tag_we              = 1'b1;
                    lu_we               = 1'b1;
                    valid_next[way_reg] = 1'b1;
                    state_next          = S_DONE;
                end
                else
                begin
                    fill_cnt_next = fill_cnt_reg + FILL_W'(1);
                end
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_load           = 1'b1;
                    rsp_next.read_data = rdata_reg;
                    rsp_next.hit       = hit_reg;
                    rsp_next.org_error = (org_reg == ORG_INVALID);
                    rsp_next.total_time = time_reg;
                    rsp_next.miss_total = miss_reg;
                    state_next         = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        time_next = time_clr ? '0 : (time_reg + time_inc);

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            clr_cnt_reg     <= '0;
            org_reg         <= ORG_DIRECT;
            stamp_reg       <= '0;
            time_reg        <= '0;
            miss_reg        <= '0;
            mode_reg        <= '0;
            addr_reg        <= '0;
            wval_reg        <= '0;
            tag_req_reg     <= '0;
            step_reg        <= '0;
            scan_idx_reg    <= '0;
            victim_reg      <= '0;
            least_reg       <= '0;
            victim_done_reg <= 1'b0;
            way_reg         <= '0;
            fill_cnt_reg    <= '0;
            rdata_reg       <= '0;
            hit_reg         <= 1'b0;
            valid_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_reg         <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            clr_cnt_reg     <= clr_cnt_next;
            org_reg         <= org_next;
            stamp_reg       <= stamp_next;
            time_reg        <= time_next;
            miss_reg        <= miss_next;
            mode_reg        <= mode_next;
            addr_reg        <= addr_next;
            wval_reg        <= wval_next;
            tag_req_reg     <= tag_req_next;
            step_reg        <= step_next;
            scan_idx_reg    <= scan_idx_next;
            victim_reg      <= victim_next;
            least_reg       <= least_next;
            victim_done_reg <= victim_done_next;
            way_reg         <= way_next;
            fill_cnt_reg    <= fill_cnt_next;
            rdata_reg       <= rdata_next;
            hit_reg         <= hit_next;
            valid_reg       <= valid_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_reg         <= rsp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            line_tag_reg[way_reg] <= tag_req_reg;
        end
        if (lu_we)
        begin
            line_last_use_reg[lu_way] <= stamp_reg;
        end
    end

endmodule
